FILE: src/tlvp_pkg.sv
// tlvp_pkg: shared types, codes and constants of the tlv container parser
// used by every module under src, no dependencies

package tlvp_pkg;

  localparam int MAGIC_BYTES  = 11;
  localparam int MAGIC_PADDED = 12;
  localparam int HEADER_BYTES = 8;
  localparam int OFF_W        = 24;
  localparam int ID_W         = 32;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_MAGIC  = 3'd1,
    PH_HEADER = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_NO_IMAGE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_CONTAINER_LENGTH = 2'd0,
    CFG_IMAGE_ID         = 2'd1,
    CFG_OTP_ID           = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [OFF_W-1:0] container_length;
    logic [ID_W-1:0]  image_id;
    logic [ID_W-1:0]  otp_id;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [OFF_W-1:0] image_offset;
    logic [OFF_W-1:0] image_length;
    logic [OFF_W-1:0] otp_offset;
    logic [OFF_W-1:0] otp_length;
    logic [ID_W-1:0]  bad_element_id;
  } result_t;

  // expected magic byte at a given index, pad byte and beyond read as zero
  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h51;
      4'd1:    b = 8'h43;
      4'd2:    b = 8'h41;
      4'd3:    b = 8'h2D;
      4'd4:    b = 8'h41;
      4'd5:    b = 8'h54;
      4'd6:    b = 8'h48;
      4'd7:    b = 8'h31;
      4'd8:    b = 8'h30;
      4'd9:    b = 8'h4B;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: src/firmware_container_tlv_parser.sv
// firmware_container_tlv_parser: top level, configuration registers and channels
// depends on tlvp_pkg, tlvp_walker and tlvp_out_reg
//
// usage
//   - write container_length (index 0) and, if needed, the image and otp ids
//     (index 1, 2) on the cfg port while the parser is idle; cfg_ready is
//     always high, a write to an unknown index is dropped
//   - stream the container one byte per word on the in_ channel, with
//     in_start_req high on the first byte; a new start drops any parse in hand
//   - one result word appears on the out_ channel when a parse ends: ok, bad
//     magic, truncated element or no image, with the recorded payload offsets
//   - throughput is one byte per clock while in_stall is low: each byte is folded
//     into the state registers by a single pass of compare and add logic
//   - the result is registered: the outcome of the byte taken at an edge is
//     shown on out_valid right after that edge, held in the result register
//   - in_stall rises only while a result sits in the result register and the
//     receiver stalls it; the register can be reloaded in the cycle it is taken
//   - reset (rst_n low, synchronous) empties the result register, idles the
//     parser and restores the register defaults (length 0, ids 3 and 4)

module firmware_container_tlv_parser #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_req,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [23:0] out_image_offset,
  output logic [23:0] out_image_length,
  output logic [23:0] out_otp_offset,
  output logic [23:0] out_otp_length,
  output logic [31:0] out_bad_element_id
);

  tlvp_pkg::cfg_t    cfg_r, cfg_nxt;
  logic              byte_acc;
  logic              res_vld;
  logic              busy;
  tlvp_pkg::result_t res;
  tlvp_pkg::result_t out_res;

  assign cfg_ready = 1'b1;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (tlvp_pkg::cfg_idx_t'(cfg_index))
        tlvp_pkg::CFG_CONTAINER_LENGTH: cfg_nxt.container_length = cfg_data[23:0];
        tlvp_pkg::CFG_IMAGE_ID:         cfg_nxt.image_id         = cfg_data;
        tlvp_pkg::CFG_OTP_ID:           cfg_nxt.otp_id           = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.container_length <= '0;
      cfg_r.image_id         <= 32'd3;
      cfg_r.otp_id           <= 32'd4;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a word is taken whenever the result register can absorb its outcome
  assign in_stall = busy;
  assign byte_acc = in_valid & ~busy;

  tlvp_walker #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .byte_acc  (byte_acc),
    .data_byte (in_data_byte),
    .start_req (in_start_req),
    .res_vld   (res_vld),
    .res       (res)
  );

  tlvp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status         = out_res.status;
  assign out_image_offset   = out_res.image_offset;
  assign out_image_length   = out_res.image_length;
  assign out_otp_offset     = out_res.otp_offset;
  assign out_otp_length     = out_res.otp_length;
  assign out_bad_element_id = out_res.bad_element_id;

endmodule

FILE: src/tlvp_walker.sv
// tlvp_walker: parse state registers and the per-byte next-state logic
// depends on tlvp_pkg

module tlvp_walker #(
  parameter int LENGTH_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tlvp_pkg::cfg_t   cfg,
  input  logic             byte_acc,
  input  logic [7:0]       data_byte,
  input  logic             start_req,
  output logic             res_vld,
  output tlvp_pkg::result_t res
);

  localparam int LW = LENGTH_BITS;

  tlvp_pkg::phase_t phase_r, phase_nxt, ph_c;
  logic [3:0]       bif_r, bif_nxt, bif_c, bif1;
  logic [LW-1:0]    bl_r, bl_nxt, bl_c, bl1;
  logic [LW-1:0]    pos_r, pos_nxt, pos_c, pos1;
  logic [LW-1:0]    sk_r, sk_nxt, sk_c, sk1;
  logic [63:0]      hdr_r, hdr_nxt, hdr_c, hdr_w;
  logic [tlvp_pkg::OFF_W-1:0] img_off_r, img_off_nxt, img_off_c;
  logic [tlvp_pkg::OFF_W-1:0] img_len_r, img_len_nxt, img_len_c;
  logic [tlvp_pkg::OFF_W-1:0] otp_off_r, otp_off_nxt, otp_off_c;
  logic [tlvp_pkg::OFF_W-1:0] otp_len_r, otp_len_nxt, otp_len_c;
  logic             img_ok_r, img_ok_nxt, img_ok_c;
  logic [31:0]      hid, hlen;
  logic [32:0]      len_p3, pad;
  logic             do_bnd;
  tlvp_pkg::status_t st;
  logic [tlvp_pkg::ID_W-1:0] bad_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tlvp_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bif_r     <= bif_nxt;
    bl_r      <= bl_nxt;
    pos_r     <= pos_nxt;
    sk_r      <= sk_nxt;
    hdr_r     <= hdr_nxt;
    img_off_r <= img_off_nxt;
    img_len_r <= img_len_nxt;
    otp_off_r <= otp_off_nxt;
    otp_len_r <= otp_len_nxt;
    img_ok_r  <= img_ok_nxt;
  end

  // start of a container clears the working state before the byte is used
  always_comb begin
    if (start_req) begin
      ph_c      = tlvp_pkg::PH_MAGIC;
      bif_c     = '0;
      bl_c      = LW'(cfg.container_length);
      pos_c     = '0;
      sk_c      = '0;
      hdr_c     = '0;
      img_off_c = '0;
      img_len_c = '0;
      otp_off_c = '0;
      otp_len_c = '0;
      img_ok_c  = 1'b0;
    end else begin
      ph_c      = phase_r;
      bif_c     = bif_r;
      bl_c      = bl_r;
      pos_c     = pos_r;
      sk_c      = sk_r;
      hdr_c     = hdr_r;
      img_off_c = img_off_r;
      img_len_c = img_len_r;
      otp_off_c = otp_off_r;
      otp_len_c = otp_len_r;
      img_ok_c  = img_ok_r;
    end
  end

  assign bif1 = bif_c + 4'd1;
  assign pos1 = pos_c + LW'(1);
  assign bl1  = (bl_c != '0) ? bl_c - LW'(1) : bl_c;
  assign sk1  = (sk_c != '0) ? sk_c - LW'(1) : sk_c;

  // header byte lands in its lane
  always_comb begin
    hdr_w = hdr_c;
    for (int k = 0; k < tlvp_pkg::HEADER_BYTES; k++) begin
      if (bif_c[2:0] == 3'(k)) begin
        hdr_w[8*k +: 8] = hdr_c[8*k +: 8] | data_byte;
      end
    end
  end

  assign hid    = hdr_w[31:0];
  assign hlen   = hdr_w[63:32];
  assign len_p3 = {1'b0, hlen} + 33'd3;
  assign pad    = {len_p3[32:2], 2'b00};

  always_comb begin
    phase_nxt   = phase_r;
    bif_nxt     = bif_r;
    bl_nxt      = bl_r;
    pos_nxt     = pos_r;
    sk_nxt      = sk_r;
    hdr_nxt     = hdr_r;
    img_off_nxt = img_off_r;
    img_len_nxt = img_len_r;
    otp_off_nxt = otp_off_r;
    otp_len_nxt = otp_len_r;
    img_ok_nxt  = img_ok_r;
    res_vld     = 1'b0;
    st          = tlvp_pkg::ST_OK;
    bad_id      = '0;
    do_bnd      = 1'b0;

    if (byte_acc) begin
      phase_nxt   = ph_c;
      bif_nxt     = bif_c;
      bl_nxt      = bl_c;
      pos_nxt     = pos_c;
      sk_nxt      = sk_c;
      hdr_nxt     = hdr_c;
      img_off_nxt = img_off_c;
      img_len_nxt = img_len_c;
      otp_off_nxt = otp_off_c;
      otp_len_nxt = otp_len_c;
      img_ok_nxt  = img_ok_c;

      if (start_req && (bl_c < LW'(tlvp_pkg::MAGIC_BYTES))) begin
        // container too short to hold the magic
        res_vld   = 1'b1;
        st        = tlvp_pkg::ST_BAD_MAGIC;
        phase_nxt = tlvp_pkg::PH_DONE;
      end else if (ph_c == tlvp_pkg::PH_MAGIC || ph_c == tlvp_pkg::PH_HEADER ||
                   ph_c == tlvp_pkg::PH_SKIP) begin
        pos_nxt = pos1;
        bl_nxt  = bl1;
        unique case (ph_c)
          tlvp_pkg::PH_MAGIC: begin
            if ((bif_c < 4'(tlvp_pkg::MAGIC_BYTES)) &&
                (data_byte != tlvp_pkg::magic_byte(bif_c))) begin
              res_vld   = 1'b1;
              st        = tlvp_pkg::ST_BAD_MAGIC;
              phase_nxt = tlvp_pkg::PH_DONE;
            end else begin
              bif_nxt = bif1;
              do_bnd  = (bif1 >= 4'(tlvp_pkg::MAGIC_PADDED)) || (bl1 == '0);
            end
          end
          tlvp_pkg::PH_HEADER: begin
            hdr_nxt = hdr_w;
            bif_nxt = bif1;
            if (bif1 >= 4'(tlvp_pkg::HEADER_BYTES)) begin
              if ({1'b0, hlen} > 33'(bl1)) begin
                res_vld   = 1'b1;
                st        = tlvp_pkg::ST_TRUNCATED;
                bad_id    = hid;
                phase_nxt = tlvp_pkg::PH_DONE;
              end else begin
                if (hid == cfg.image_id) begin
                  img_off_nxt = tlvp_pkg::OFF_W'(pos1);
                  img_len_nxt = hlen[tlvp_pkg::OFF_W-1:0];
                  img_ok_nxt  = (hlen != 32'd0);
                end else if (hid == cfg.otp_id) begin
                  otp_off_nxt = tlvp_pkg::OFF_W'(pos1);
                  otp_len_nxt = hlen[tlvp_pkg::OFF_W-1:0];
                end
                // pad clamped to what is left of the container
                sk_nxt = (pad > 33'(bl1)) ? bl1 : pad[LW-1:0];
                if (sk_nxt == '0) begin
                  do_bnd = 1'b1;
                end else begin
                  phase_nxt = tlvp_pkg::PH_SKIP;
                end
              end
            end
          end
          tlvp_pkg::PH_SKIP: begin
            sk_nxt = sk1;
            do_bnd = (sk1 == '0);
          end
          default: begin
          end
        endcase

        if (do_bnd) begin
          if (bl1 <= LW'(tlvp_pkg::HEADER_BYTES)) begin
            res_vld   = 1'b1;
            st        = img_ok_nxt ? tlvp_pkg::ST_OK : tlvp_pkg::ST_NO_IMAGE;
            phase_nxt = tlvp_pkg::PH_DONE;
          end else begin
            phase_nxt = tlvp_pkg::PH_HEADER;
            bif_nxt   = '0;
            hdr_nxt   = '0;
          end
        end
      end
    end
  end

  always_comb begin
    res.status         = st;
    res.image_offset   = img_off_nxt;
    res.image_length   = img_len_nxt;
    res.otp_offset     = otp_off_nxt;
    res.otp_length     = otp_len_nxt;
    res.bad_element_id = bad_id;
  end

endmodule

FILE: src/tlvp_out_reg.sv
// tlvp_out_reg: result register between the parser and the result channel
// depends on tlvp_pkg

module tlvp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_vld,
  input  tlvp_pkg::result_t res,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output tlvp_pkg::result_t out_res
);

  logic              vld_r, vld_nxt;
  tlvp_pkg::result_t res_r;

  // full and not being taken this cycle
  assign busy = vld_r & out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (res_vld) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule
